@@ hdl/efrc_pkg.sv @@
`default_nettype none

package efrc_pkg;

  // Floor count of the building; the floor field is one-based and 5 bits wide,
  // so the count stays at or below 31.
  localparam int FLOORS  = 16;
  localparam int FLOOR_W = 5;
  localparam int IDX_W   = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int DIR_W   = 2;

  // Stream widths
  localparam int S_DATA_W = ((FLOOR_W + DIR_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((2 * FLOOR_W + 1 + 7) / 8) * 8;

  typedef enum logic {
    REQ_PRESS = 1'b0,
    REQ_PASS  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    MODE_FREE = 2'd0,
    MODE_GOT  = 2'd1,
    MODE_BUSY = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_MOVE  = 2'd1,
    ACT_CONT  = 2'd2,
    ACT_FINAL = 2'd3
  } act_t;

  typedef struct packed {
    req_t               req_type;
    logic [FLOOR_W-1:0] floor;
    logic [DIR_W-1:0]   travel_dir;
  } item_t;

  typedef struct packed {
    act_t               action;
    logic [FLOOR_W-1:0] at_floor;
    logic [FLOOR_W-1:0] goal_floor;
    logic               release_valid;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/elevator_floor_request_controller_core.sv @@
// Elevator floor request controller.
//
// Input channel (s_*): one transaction per event. s_tuser carries the event
// kind (press or floor passed), s_tdata the floor and the cab direction.
// Output channel (m_*): exactly one transaction per event. m_tuser carries the
// action (none, move, stop and continue, final stop), m_tdata the cab floor,
// the goal floor and the button release flag.
//
// An event sits in an input register, is evaluated combinationally by the
// request search and state update, and lands in the result register, which
// drives m_tvalid. Throughput is one event per cycle while the receiver takes
// results, since the target search over the request map is combinational.
//
// Reset clears both valid flags, marks every floor as visited, parks the cab at
// floor 1 with goal 1, stopped, in free mode. While the receiver stalls, the
// result register holds and one more event is taken into the input register;
// s_tready then drops until the result is taken.
`default_nettype none

module elevator_floor_request_controller_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [4:0] floor, [6:5] travel_dir, [7] zero
  input  logic [efrc_pkg::S_DATA_W-1:0] s_tdata,
  // [0] req_type
  input  logic [0:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [4:0] at_floor, [9:5] goal_floor, [10] release_valid, [15:11] zero
  output logic [efrc_pkg::M_DATA_W-1:0] m_tdata,
  // [1:0] action
  output logic [1:0]                    m_tuser
);
  import efrc_pkg::*;

  logic  in_valid;
  item_t in_item;
  logic  out_valid;
  res_t  out_res;
  res_t  step_res;
  logic  advance;

  // Move the held event forward when the result register is free or drains
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type   <= req_t'(s_tuser[0]);
      in_item.floor      <= s_tdata[FLOOR_W-1:0];
      in_item.travel_dir <= s_tdata[FLOOR_W+DIR_W-1:FLOOR_W];
    end
  end

  efrc_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .go   (advance),
    .item (in_item),
    .res  (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.action;
  assign m_tdata  = {{(M_DATA_W - 2*FLOOR_W - 1){1'b0}}, out_res.release_valid,
                     out_res.goal_floor, out_res.at_floor};

endmodule

`default_nettype wire

@@ hdl/efrc_search.sv @@
`default_nettype none

module efrc_search (
  input  logic [efrc_pkg::FLOORS-1:0] req,
  input  logic [efrc_pkg::IDX_W-1:0]  cab_idx,
  input  logic                        up_first,
  output logic                        found,
  output logic [efrc_pkg::IDX_W-1:0]  hit_idx
);
  import efrc_pkg::*;

  logic [FLOORS-1:0] above;
  logic [FLOORS-1:0] below;
  logic              up_found;
  logic              dn_found;
  logic [IDX_W-1:0]  up_idx;
  logic [IDX_W-1:0]  dn_idx;

  // Split the request map at the cab floor, cab floor on both sides
  always_comb begin
    for (int i = 0; i < FLOORS; i++) begin
      above[i] = req[i] && (i >= int'(cab_idx));
      below[i] = req[i] && (i <= int'(cab_idx));
    end
  end

  // Nearest request going up: lowest set bit at or above the cab
  always_comb begin
    up_idx = '0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (above[i]) up_idx = IDX_W'(i);
    end
  end

  // Nearest request going down: highest set bit at or below the cab
  always_comb begin
    dn_idx = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (below[i]) dn_idx = IDX_W'(i);
    end
  end

  assign up_found = |above;
  assign dn_found = |below;
  assign found    = up_found || dn_found;

  // Prefer up when up_first is set, else down; fall back to the other one
  always_comb begin
    if (up_first) begin
      hit_idx = up_found ? up_idx : dn_idx;
    end else begin
      hit_idx = dn_found ? dn_idx : up_idx;
    end
  end

endmodule

`default_nettype wire

@@ hdl/efrc_engine.sv @@
`default_nettype none

module efrc_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  efrc_pkg::item_t item,
  output efrc_pkg::res_t  res
);
  import efrc_pkg::*;

  logic [FLOORS-1:0]  pending_map;
  logic [FLOORS-1:0]  pending_map_next;
  mode_t              mode;
  mode_t              mode_next;
  logic [FLOOR_W-1:0] cab_floor;
  logic [FLOOR_W-1:0] cab_floor_next;
  logic [FLOOR_W-1:0] goal_reg;
  logic [FLOOR_W-1:0] goal_reg_next;
  dir_t               dir_reg;
  dir_t               dir_reg_next;

  logic               fl_ok;
  logic               is_press;
  logic [IDX_W-1:0]   fl_idx;
  logic [IDX_W-1:0]   cab_idx;
  logic [IDX_W-1:0]   srv_idx;
  dir_t               td;
  dir_t               srv_dir;
  logic [FLOOR_W-1:0] srv_floor;
  logic [FLOORS-1:0]  req_cur;
  logic [FLOORS-1:0]  req_press;
  logic [FLOORS-1:0]  req_serve;
  logic [FLOORS-1:0]  fl_bit;
  logic [FLOORS-1:0]  srv_bit;
  logic               pick_found;
  logic [IDX_W-1:0]   pick_idx;
  logic [FLOOR_W-1:0] pick_floor;
  logic               next_found;
  logic [IDX_W-1:0]   next_idx;
  logic [FLOOR_W-1:0] next_floor;
  logic               do_serve;
  act_t               action;
  logic               release_valid;

  // Decode the event
  assign is_press = (item.req_type == REQ_PRESS);
  assign fl_ok    = (item.floor != '0) && (item.floor <= FLOOR_W'(FLOORS));
  assign fl_idx   = IDX_W'(item.floor - FLOOR_W'(1));
  assign cab_idx  = IDX_W'(cab_floor - FLOOR_W'(1));

  // Map unknown direction code to stopped
  always_comb begin
    case (item.travel_dir)
      DIR_UP:   td = DIR_UP;
      DIR_DOWN: td = DIR_DOWN;
      default:  td = DIR_STOP;
    endcase
  end

  // Request maps: current, after the press, after serving the cab floor
  assign req_cur   = ~pending_map;
  assign fl_bit    = {{(FLOORS-1){1'b0}}, 1'b1} << fl_idx;
  assign req_press = req_cur | fl_bit;

  assign srv_idx   = is_press ? cab_idx : fl_idx;
  assign srv_dir   = is_press ? dir_reg : td;
  assign srv_floor = is_press ? cab_floor : item.floor;
  assign srv_bit   = {{(FLOORS-1){1'b0}}, 1'b1} << srv_idx;
  assign req_serve = (is_press ? req_press : req_cur) & ~srv_bit;

  // Target pick for a press
  efrc_search u_pick (
    .req      (req_press),
    .cab_idx  (cab_idx),
    .up_first (dir_reg == DIR_UP),
    .found    (pick_found),
    .hit_idx  (pick_idx)
  );

  // Next target once the cab floor is served
  efrc_search u_next (
    .req      (req_serve),
    .cab_idx  (srv_idx),
    .up_first (srv_dir == DIR_UP),
    .found    (next_found),
    .hit_idx  (next_idx)
  );

  assign pick_floor = FLOOR_W'(pick_idx) + FLOOR_W'(1);
  assign next_floor = FLOOR_W'(next_idx) + FLOOR_W'(1);

  // Next state and result for one event
  always_comb begin
    pending_map_next = pending_map;
    mode_next        = mode;
    cab_floor_next   = cab_floor;
    goal_reg_next    = goal_reg;
    dir_reg_next     = dir_reg;
    action           = ACT_NONE;
    release_valid    = 1'b0;
    do_serve         = 1'b0;

    if (fl_ok) begin
      if (is_press) begin
        pending_map_next = ~req_press;
        if (mode != MODE_GOT) begin
          // A pending cab floor is always the nearest pick: serve at once
          if (req_press[cab_idx]) begin
            do_serve = 1'b1;
          end else begin
            mode_next     = MODE_GOT;
            goal_reg_next = pick_found ? pick_floor : item.floor;
            dir_reg_next  = (pick_idx > cab_idx) ? DIR_UP : DIR_DOWN;
            action        = ACT_MOVE;
          end
        end
      end else if (mode == MODE_GOT || mode == MODE_BUSY) begin
        mode_next      = MODE_BUSY;
        cab_floor_next = item.floor;
        dir_reg_next   = td;
        if (item.floor == goal_reg) do_serve = 1'b1;
      end
    end

    // Serve the cab floor: release, then continue or stop for good
    if (do_serve) begin
      release_valid    = 1'b1;
      pending_map_next = ~req_serve;
      if (next_found) begin
        mode_next     = MODE_BUSY;
        goal_reg_next = next_floor;
        action        = ACT_CONT;
      end else begin
        mode_next     = MODE_FREE;
        goal_reg_next = srv_floor;
        action        = ACT_FINAL;
      end
    end
  end

  assign res.action        = action;
  assign res.at_floor      = cab_floor_next;
  assign res.goal_floor    = goal_reg_next;
  assign res.release_valid = release_valid;

  // Commit state when the event moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_map <= '1;
      mode        <= MODE_FREE;
      cab_floor   <= FLOOR_W'(1);
      goal_reg    <= FLOOR_W'(1);
      dir_reg     <= DIR_STOP;
    end else if (go) begin
      pending_map <= pending_map_next;
      mode        <= mode_next;
      cab_floor   <= cab_floor_next;
      goal_reg    <= goal_reg_next;
      dir_reg     <= dir_reg_next;
    end
  end

`ifndef SYNTH
  a_release_serves: assert property (@(posedge clk) disable iff (rst)
    go |-> (release_valid == (action == ACT_CONT || action == ACT_FINAL)))
    else $error("release does not match a serve action");

  a_final_frees: assert property (@(posedge clk) disable iff (rst)
    go && action == ACT_FINAL |=> mode == MODE_FREE && cab_floor == goal_reg)
    else $error("final stop did not free the cab at its goal");

  a_move_away: assert property (@(posedge clk) disable iff (rst)
    go && action == ACT_MOVE |=> mode == MODE_GOT && cab_floor != goal_reg)
    else $error("move issued toward the cab floor");

  a_free_idle: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_FREE |-> &pending_map)
    else $error("free mode with requests pending");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_elevator_floor_request_controller_core.sv @@
module tb_elevator_floor_request_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import efrc_pkg::*;

  // Spare direction code; the controller treats it as stopped
  localparam logic [DIR_W-1:0] DIR_CODE_SPARE = 2'd3;
  localparam int EVENT_TARGET = 1150;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 100;

  // One queued input event, optionally held back until all replies are in
  typedef struct packed {
    item_t ev;
    logic  drain;
  } stim_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // [4:0] floor, [6:5] travel_dir, [7] zero
  logic [S_DATA_W-1:0] s_tdata = '0;
  // [0] req_type
  logic [0:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // [4:0] at_floor, [9:5] goal_floor, [10] release_valid, [15:11] zero
  logic [M_DATA_W-1:0] m_tdata;
  // [1:0] action
  logic [1:0]          m_tuser;

  elevator_floor_request_controller_core dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // Controller state as predicted here; call_open set = floor still requested
  logic [FLOORS-1:0]  call_open;
  mode_t              mode_now;
  logic [FLOOR_W-1:0] cab_at;
  logic [FLOOR_W-1:0] goal_at;
  dir_t               dir_now;

  stim_t event_q[$];
  res_t  due_actions[$];

  item_t cur_event;
  bit    hold_next;
  int    in_range_events;
  bit    s_fire;
  bit    m_fire;
  int    tx_gap;
  int    tx_burst;
  int    rx_wait;
  int    rx_burst;
  int    err_cnt;
  int    idle_cycles;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= PRINT_CAP) $display("%0t: %s", $time, msg);
  endtask

  // Mostly short gaps, a few long ones, and occasional stretches of none
  function automatic int gap_len(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Walk from the cab floor one way; return the first requested floor or zero
  function automatic logic [FLOOR_W-1:0] nearest_request(input bit upward);
    int i;
    i = int'(cab_at) - 1;
    while (i >= 0 && i < FLOORS) begin
      if (call_open[i]) return FLOOR_W'(i + 1);
      i = upward ? i + 1 : i - 1;
    end
    return '0;
  endfunction

  // Search the travel direction first, down when stopped, then the other way
  function automatic logic [FLOOR_W-1:0] pick_goal();
    logic [FLOOR_W-1:0] f;
    f = nearest_request(dir_now == DIR_UP);
    if (f == '0) f = nearest_request(dir_now != DIR_UP);
    return f;
  endfunction

  // Clear the cab floor's call, then continue to the next call or park
  function automatic act_t serve_cab_floor();
    logic [FLOOR_W-1:0] nxt;
    call_open[cab_at - 1] = 1'b0;
    nxt = pick_goal();
    if (nxt != '0) begin
      goal_at = nxt;
      return ACT_CONT;
    end
    mode_now = MODE_FREE;
    return ACT_FINAL;
  endfunction

  // Advance the predicted state by one event and return the reply it causes
  function automatic res_t resolve_event(input item_t ev);
    res_t               r;
    dir_t               td;
    logic [FLOOR_W-1:0] g;
    r.action        = ACT_NONE;
    r.release_valid = 1'b0;
    td = (ev.travel_dir == DIR_CODE_SPARE) ? DIR_STOP : dir_t'(ev.travel_dir);
    if (ev.floor >= 1 && ev.floor <= FLOORS) begin
      if (ev.req_type == REQ_PRESS) begin
        call_open[ev.floor - 1] = 1'b1;
        if (mode_now != MODE_GOT) begin
          g        = pick_goal();
          mode_now = MODE_GOT;
          goal_at  = (g != '0) ? g : ev.floor;
          if (cab_at == goal_at) begin
            mode_now        = MODE_BUSY;
            r.release_valid = 1'b1;
            r.action        = serve_cab_floor();
          end else begin
            dir_now  = (goal_at > cab_at) ? DIR_UP : DIR_DOWN;
            r.action = ACT_MOVE;
          end
        end
      end else if (mode_now != MODE_FREE) begin
        mode_now = MODE_BUSY;
        cab_at   = ev.floor;
        dir_now  = td;
        if (cab_at == goal_at) begin
          r.release_valid = 1'b1;
          r.action        = serve_cab_floor();
        end
      end
    end
    r.at_floor   = cab_at;
    r.goal_floor = goal_at;
    return r;
  endfunction

  task automatic add_event(input req_t k, input int fl, input logic [DIR_W-1:0] td);
    stim_t s;
    s.ev.req_type   = k;
    s.ev.floor      = FLOOR_W'(fl);
    s.ev.travel_dir = td;
    s.drain         = hold_next;
    hold_next       = 1'b0;
    event_q.insert(event_q.size(), s);
    if (fl >= 1 && fl <= FLOORS) in_range_events++;
  endtask

  function automatic logic [DIR_W-1:0] rand_dir_code();
    return DIR_W'($urandom_range(0, 3));
  endfunction

  // Sample both channels, predict, check, and watch for a stall
  always @(posedge clk) begin : mon_blk
    res_t want;
    s_fire = !rst && s_tvalid && s_tready;
    m_fire = !rst && m_tvalid && m_tready;
    if (m_fire) begin
      if (due_actions.size() == 0) begin
        report($sformatf("reply with none pending: action %0d tdata %h", m_tuser, m_tdata));
      end else begin
        want = due_actions.pop_front();
        if (act_t'(m_tuser) != want.action)
          report($sformatf("action got %0d want %0d", m_tuser, want.action));
        if (m_tdata[FLOOR_W-1:0] != want.at_floor)
          report($sformatf("at_floor got %0d want %0d", m_tdata[FLOOR_W-1:0],
                           want.at_floor));
        if (m_tdata[2*FLOOR_W-1:FLOOR_W] != want.goal_floor)
          report($sformatf("goal_floor got %0d want %0d",
                           m_tdata[2*FLOOR_W-1:FLOOR_W], want.goal_floor));
        if (m_tdata[2*FLOOR_W] != want.release_valid)
          report($sformatf("release_valid got %0d want %0d", m_tdata[2*FLOOR_W],
                           want.release_valid));
      end
    end
    if (s_fire) begin
      due_actions.insert(due_actions.size(),
                         resolve_event(item_t'({s_tuser[0], s_tdata[FLOOR_W-1:0],
                                                s_tdata[FLOOR_W+DIR_W-1:FLOOR_W]})));
    end
    if (!rst) begin
      if (s_fire || m_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Present queued events with random gaps; hold a draining event back
  always @(negedge clk) begin : drv_blk
    logic  nxt_valid;
    stim_t s;
    nxt_valid = s_tvalid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (s_fire) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (event_q.size() > 0 &&
                     !(event_q[0].drain && due_actions.size() != 0)) begin
          s         = event_q.pop_front();
          cur_event = s.ev;
          nxt_valid = 1'b1;
          tx_gap    = gap_len(tx_burst);
        end
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata  <= S_DATA_W'({cur_event.travel_dir, cur_event.floor});
    s_tuser  <= cur_event.req_type;
  end

  // Stall the reply channel at random
  always @(negedge clk) begin : rx_blk
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_fire) rx_wait = gap_len(rx_burst);
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : main_blk
    int pos;
    int dest;
    int k;
    int r;
    call_open = '0;
    mode_now  = MODE_FREE;
    cab_at    = FLOOR_W'(1);
    goal_at   = FLOOR_W'(1);
    dir_now   = DIR_STOP;
    cur_event = '0;

    // Directed: out-of-range floors, ignored passes, serve at the cab floor,
    // press while a target is held, spare direction code, continue and park
    add_event(REQ_PRESS, 0, DIR_STOP);
    add_event(REQ_PRESS, 17, DIR_UP);
    add_event(REQ_PASS, 31, DIR_CODE_SPARE);
    add_event(REQ_PASS, 5, DIR_UP);
    add_event(REQ_PRESS, 1, DIR_STOP);
    add_event(REQ_PRESS, FLOORS, DIR_DOWN);
    add_event(REQ_PRESS, 8, DIR_STOP);
    add_event(REQ_PRESS, 31, DIR_CODE_SPARE);
    add_event(REQ_PASS, 2, DIR_CODE_SPARE);
    add_event(REQ_PASS, 0, DIR_UP);
    add_event(REQ_PASS, 9, DIR_UP);
    add_event(REQ_PASS, FLOORS, DIR_UP);
    add_event(REQ_PRESS, 3, DIR_UP);
    add_event(REQ_PASS, 8, DIR_DOWN);
    add_event(REQ_PASS, 3, DIR_DOWN);
    add_event(REQ_PRESS, FLOORS, DIR_CODE_SPARE);
    add_event(REQ_PASS, FLOORS, DIR_DOWN);
    add_event(REQ_PRESS, 1, DIR_STOP);
    add_event(REQ_PRESS, FLOORS, DIR_STOP);
    add_event(REQ_PRESS, 10, DIR_UP);
    add_event(REQ_PASS, 1, DIR_STOP);
    add_event(REQ_PASS, 10, DIR_CODE_SPARE);
    add_event(REQ_PASS, FLOORS, DIR_UP);
    add_event(REQ_PASS, FLOORS, DIR_UP);

    // Random: mostly trips of presses followed by a cab walk, some noise
    hold_next = 1'b1;
    pos       = 1;
    while (in_range_events < EVENT_TARGET) begin
      if ($urandom_range(0, 49) == 0) hold_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 12) begin
        add_event(req_t'($urandom_range(0, 1)), $urandom_range(0, 31), rand_dir_code());
      end else begin
        k    = $urandom_range(1, 4);
        dest = pos;
        repeat (k) begin
          dest = $urandom_range(1, FLOORS);
          add_event(REQ_PRESS, dest, rand_dir_code());
        end
        if (dest == pos) begin
          add_event(REQ_PASS, pos, DIR_STOP);
        end
        while (pos != dest) begin
          pos = (dest > pos) ? pos + 1 : pos - 1;
          if ($urandom_range(0, 99) < 85)
            add_event(REQ_PASS, pos, (dest >= pos) ? DIR_UP : DIR_DOWN);
          else
            add_event(REQ_PASS, pos, rand_dir_code());
          if ($urandom_range(0, 9) == 0)
            add_event(REQ_PRESS, $urandom_range(1, FLOORS), rand_dir_code());
          // break off a trip now and then
          if ($urandom_range(0, 39) == 0) break;
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every event to go in and every reply to come back
    while (event_q.size() != 0 || s_tvalid) @(posedge clk);
    while (due_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/efrc_pkg.sv
hdl/efrc_search.sv
hdl/efrc_engine.sv
hdl/elevator_floor_request_controller_core.sv
tb/sv/tb_elevator_floor_request_controller_core.sv
